// File: src/cbp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbp_pkg: shared types and constants
// Widths, probability constants, sequencer states and divider types for the binomial CDF.
// ---------------------------------------------------------------------------
package cbp_pkg;

  localparam int FRAC_BITS  = 32;
  localparam int MAX_TRIALS = 1023;
  localparam int N_W        = 10;
  localparam int K_W        = 11;
  localparam int P_W        = FRAC_BITS + 1;
  // Numerator of a recurrence step: 33 x 33 x 10 bits.
  localparam int NUM_W      = 2 * P_W + N_W;
  // Divisor (j+1)*q: 11 x 33 bits.
  localparam int DEN_W      = K_W + P_W;
  localparam logic [P_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW_MUL,
    ST_POW_WB,
    ST_ADD,
    ST_MUL_P,
    ST_MUL_N,
    ST_MUL_NH,
    ST_MUL_D,
    ST_DIV,
    ST_DIV_WB,
    ST_DONE
  } state_t;

  // Commands from the sequencer to the serial divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: src/cbp_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbp_div: restoring divider
// One quotient bit per cycle; the quotient saturates to ONE.
// ---------------------------------------------------------------------------
module cbp_div
  import cbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_sts_t         sts,
  output logic [P_W-1:0]   quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   shifted;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    if (ctl.start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      if (shifted >= {1'b0, den}) begin
        rem_nxt = shifted - {1'b0, den};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot = (q_r > NUM_W'(ONE)) ? ONE : q_r[P_W-1:0];

endmodule

// File: src/cumulative_binomial_probability.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cumulative_binomial_probability: binomial CDF P(X<k)
// Sequencer around one shared multiplier and one serial divider.
// ---------------------------------------------------------------------------
//  channel  | ports                                     | timing
//  in       | start, busy, in_trials/threshold/success  | taken on start & !busy
//  out      | out_valid, out_cumulative_prob            | one-cycle strobe
//
// Special cases (k > n, p = 0, p = 1) go straight to the done state. Otherwise
// (1-p)^n is built by one multiply and one writeback per trial, and each summed
// term passes through the multiply states and then waits on the 76-step divider.
// Reset clears the sequencer; busy stays high until the result strobe.
// The receiver cannot stall; out_valid is never held.
module cumulative_binomial_probability
  import cbp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [N_W-1:0] in_trials,
  input  logic [K_W-1:0] in_threshold,
  input  logic [P_W-1:0] in_success_prob,
  output logic           out_valid,
  output logic [P_W-1:0] out_cumulative_prob
);

  state_t st_r, st_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [P_W-1:0]   p_r, p_nxt, q_r, q_nxt;
  logic [P_W-1:0]   term_r, term_nxt, sum_r, sum_nxt, res_r, res_nxt;
  logic [K_W-1:0]   j_r, j_nxt;
  logic [NUM_W-1:0] prod_r, prod_nxt;
  logic [P_W+N_W-1:0] part_r, part_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             valid_r, valid_nxt;
  logic [P_W-1:0]   pin;
  logic [P_W:0]     sum_add;
  logic [2*P_W-1:0] pow_full;
  div_ctl_t         dctl;
  div_sts_t         dsts;
  logic [P_W-1:0]   quot;

  // The one shared multiplier; its operands are picked by state.
  logic [P_W-1:0]   mul_a, mul_b;
  logic [2*P_W-1:0] mul_y;

  cbp_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .num(prod_r), .den(den_r),
    .sts(dsts), .quot(quot)
  );

  assign pin = (in_success_prob > ONE) ? ONE : in_success_prob;

  // The 66-bit product term*p is scaled by (n-j) one 33-bit half at a time.
  always_comb begin
    mul_a = term_r;
    mul_b = q_r;
    case (st_r)
      ST_MUL_P: begin
        mul_a = term_r;
        mul_b = p_r;
      end
      ST_MUL_N: begin
        mul_a = prod_r[P_W-1:0];
        mul_b = P_W'(n_r - j_r[N_W-1:0]);
      end
      ST_MUL_NH: begin
        mul_a = prod_r[2*P_W-1:P_W];
        mul_b = P_W'(n_r - j_r[N_W-1:0]);
      end
      ST_MUL_D: begin
        mul_a = P_W'(j_r + 1'b1);
        mul_b = q_r;
      end
      default: ;
    endcase
    mul_y = {{P_W{1'b0}}, mul_a} * {{P_W{1'b0}}, mul_b};
  end

  always_comb begin
    st_nxt    = st_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    term_nxt  = term_r;
    sum_nxt   = sum_r;
    res_nxt   = res_r;
    j_nxt     = j_r;
    prod_nxt  = prod_r;
    part_nxt  = part_r;
    den_nxt   = den_r;
    valid_nxt = 1'b0;
    dctl.start = 1'b0;
    sum_add   = {1'b0, sum_r} + {1'b0, term_r};
    pow_full  = prod_r[2*P_W-1:0] >> FRAC_BITS;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt    = in_trials;
          k_nxt    = in_threshold;
          p_nxt    = pin;
          q_nxt    = ONE - pin;
          term_nxt = ONE;
          sum_nxt  = '0;
          j_nxt    = '0;
          if ({1'b0, in_trials} < in_threshold) begin
            res_nxt = ONE;
            st_nxt  = ST_DONE;
          end else if (pin == '0) begin
            res_nxt = (in_threshold != '0) ? ONE : '0;
            st_nxt  = ST_DONE;
          end else if (pin == ONE) begin
            res_nxt = '0;
            st_nxt  = ST_DONE;
          end else if (in_trials == '0) begin
            st_nxt = ST_ADD;
          end else begin
            st_nxt = ST_POW_MUL;
          end
        end
      end
      ST_POW_MUL: begin
        prod_nxt = NUM_W'(mul_y);
        st_nxt   = ST_POW_WB;
      end
      ST_POW_WB: begin
        // Both factors are at most ONE, so the product shifted down never exceeds ONE here.
        term_nxt = pow_full[P_W-1:0];
        j_nxt    = j_r + 1'b1;
        if (j_r + 1'b1 == {1'b0, n_r}) begin
          j_nxt  = '0;
          st_nxt = ST_ADD;
        end else begin
          st_nxt = ST_POW_MUL;
        end
      end
      ST_ADD: begin
        if (j_r == k_r) begin
          res_nxt = sum_r;
          st_nxt  = ST_DONE;
        end else if (sum_add >= {1'b0, ONE}) begin
          res_nxt = ONE - 1'b1;
          st_nxt  = ST_DONE;
        end else begin
          sum_nxt = sum_add[P_W-1:0];
          if (j_r + 1'b1 < k_r && term_r != '0) begin
            st_nxt = ST_MUL_P;
          end else begin
            j_nxt  = j_r + 1'b1;
            st_nxt = ST_ADD;
          end
        end
      end
      ST_MUL_P: begin
        prod_nxt = NUM_W'(mul_y);
        st_nxt   = ST_MUL_N;
      end
      ST_MUL_N: begin
        part_nxt = mul_y[P_W+N_W-1:0];
        st_nxt   = ST_MUL_NH;
      end
      ST_MUL_NH: begin
        prod_nxt = {mul_y[P_W+N_W-1:0], {P_W{1'b0}}} + NUM_W'(part_r);
        st_nxt   = ST_MUL_D;
      end
      ST_MUL_D: begin
        den_nxt = DEN_W'(mul_y);
        st_nxt  = ST_DIV;
      end
      ST_DIV: begin
        dctl.start = 1'b1;
        st_nxt     = ST_DIV_WB;
      end
      ST_DIV_WB: begin
        if (dsts.done) begin
          term_nxt = quot;
          j_nxt    = j_r + 1'b1;
          st_nxt   = ST_ADD;
        end
      end
      ST_DONE: begin
        valid_nxt = 1'b1;
        st_nxt    = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      valid_r <= valid_nxt;
    end
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    res_r  <= res_nxt;
    j_r    <= j_nxt;
    prod_r <= prod_nxt;
    part_r <= part_nxt;
    den_r  <= den_nxt;
  end

  assign busy = (st_r != ST_IDLE) | dsts.busy;
  assign out_valid = valid_r;
  assign out_cumulative_prob = res_r;

endmodule
